// ----- src/hbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hbs_pkg;

    // Item kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Register map: word index taken from paddr[2]
    localparam logic REG_MAX_HEIGHT = 1'b0;

    localparam logic [7:0] MAX_HEIGHT_RESET = 8'd30;

    // Rounding offset for the divide by 255*256, and the 1/255 reciprocal (2^16/255)
    localparam logic [31:0] ROUND_HALF = 32'd32640;
    localparam logic [8:0]  RECIP_255  = 9'd257;
    localparam logic [23:0] FULL_SCALE = 24'd255;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_z;
        logic [7:0]         x_index;
        logic [7:0]         z_index;
        logic [7:0]         sample_value;
    } req_item_t;

    typedef struct packed {
        logic [15:0] height;
        logic        out_of_range;
    } rsp_item_t;

endpackage

`default_nettype wire

// ----- src/heightmap_bilinear_sampler_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Height-map bilinear sampler.
// The req channel carries write items (kind 0: store sample_value at
// x_index, z_index) and sample items (kind 1: position pos_x, pos_z in
// signed Q8.8). Each sample item gives one rsp item: the bilinear height
// scaled by max_height/255 in unsigned Q8.8, and a flag set when a
// neighbour index was clamped to the map edge. Write items give no rsp.
// The map sits in four banks split by x and z index parity, so all four
// neighbours are read in the cycle the item is accepted.
// Throughput: one item per cycle unless rsp_ready stalls the output, set by
// the single read port of each bank. A sample item's banks are read at the
// edge that accepts it; it then passes the z lerp, x lerp, scale, reciprocal
// multiply and correction registers before its rsp item is valid.
// When rsp_ready is low the stages fill up behind the output register and
// req_ready drops only once every stage holds an item.
// Reset clears the pipeline and sets max_height to 30. The map itself is
// not cleared: entries read before being written return undefined data.
// max_height sits at byte address 0 of the APB port; pready is always high.
module heightmap_bilinear_sampler_unit #(
    parameter int MAP_SIZE = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire hbs_pkg::req_item_t req,

    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output hbs_pkg::rsp_item_t     rsp,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int IW    = $clog2(MAP_SIZE);
    localparam int HW    = (IW > 1) ? IW - 1 : 1;
    localparam int XW    = HW + 1;
    localparam int AW    = 2 * HW;
    localparam int DEPTH = 1 << AW;

    localparam logic signed [11:0] HALF_OFS  = 12'(MAP_SIZE / 2);
    localparam logic signed [11:0] IDX_MAX_S = 12'(MAP_SIZE - 1);
    localparam logic [XW-1:0]      IDX_MAX_X = XW'(MAP_SIZE - 1);
    localparam logic [10:0]        MAP_SIZE_W = 11'(MAP_SIZE);

    function automatic logic [XW-1:0] clamp_idx(input logic signed [11:0] v);
        if (v < 12'sd0)
            return '0;
        else if (v > IDX_MAX_S)
            return IDX_MAX_X;
        else
            return v[XW-1:0];
    endfunction

    function automatic logic idx_clamped(input logic signed [11:0] v);
        return (v < 12'sd0) || (v > IDX_MAX_S);
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic [7:0] max_height_reg;
    logic [7:0] max_height_next;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == hbs_pkg::REG_MAX_HEIGHT);

    always_comb
    begin
        max_height_next = max_height_reg;
        if (cfg_wr)
        begin
            max_height_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_height_reg <= hbs_pkg::MAX_HEIGHT_RESET;
        end
        else
        begin
            max_height_reg <= max_height_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == hbs_pkg::REG_MAX_HEIGHT)
        begin
            prdata = {24'd0, max_height_reg};
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or drains forward
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, rsp_valid_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next, rsp_valid_next;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
    logic accept, accept_sample, accept_write;

    assign rdy_out = !rsp_valid_reg || rsp_ready;
    assign rdy5    = !v5_reg || rdy_out;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;

    assign req_ready     = rdy1;
    assign accept        = req_valid && rdy1;
    assign accept_sample = accept && (req.kind == hbs_pkg::KIND_SAMPLE);
    assign accept_write  = accept && (req.kind == hbs_pkg::KIND_WRITE);

    always_comb
    begin
        v1_next        = rdy1    ? accept_sample : v1_reg;
        v2_next        = rdy2    ? v1_reg        : v2_reg;
        v3_next        = rdy3    ? v2_reg        : v3_reg;
        v4_next        = rdy4    ? v3_reg        : v4_reg;
        v5_next        = rdy5    ? v4_reg        : v5_reg;
        rsp_valid_next = rdy_out ? v5_reg        : rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            v4_reg        <= v4_next;
            v5_reg        <= v5_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Neighbour indices, clamped to the map
    // ------------------------------------------------------------------
    logic signed [11:0] ix1, ix2, iz1, iz2;
    logic [XW-1:0]      x1, x2, z1, z2;
    logic               clamp_any;

    always_comb
    begin
        ix1 = {{4{req.pos_x[15]}}, req.pos_x[15:8]} + HALF_OFS;
        ix2 = ix1 + 12'sd1;
        iz1 = {{4{req.pos_z[15]}}, req.pos_z[15:8]} + HALF_OFS;
        iz2 = iz1 + 12'sd1;
        x1  = clamp_idx(ix1);
        x2  = clamp_idx(ix2);
        z1  = clamp_idx(iz1);
        z2  = clamp_idx(iz2);
        clamp_any = idx_clamped(ix1) || idx_clamped(ix2)
                 || idx_clamped(iz1) || idx_clamped(iz2);
    end

    // ------------------------------------------------------------------
    // Write decode: drop writes outside the map
    // ------------------------------------------------------------------
    logic [XW-1:0] wx, wz;
    logic          wr_en;

    assign wx    = XW'(req.x_index);
    assign wz    = XW'(req.z_index);
    assign wr_en = accept_write
                && ({3'd0, req.x_index} < MAP_SIZE_W)
                && ({3'd0, req.z_index} < MAP_SIZE_W);

    // ------------------------------------------------------------------
    // Four parity banks
    // ------------------------------------------------------------------
    logic [7:0] bank_rdata [4];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic BX = 1'((b >> 1) & 1);
        localparam logic BZ = 1'(b & 1);

        logic [HW-1:0] rx, rz;
        logic          bank_we;

        // Pick the neighbour index whose parity matches this bank
        assign rx      = (x1[0] == BX) ? x1[XW-1:1] : x2[XW-1:1];
        assign rz      = (z1[0] == BZ) ? z1[XW-1:1] : z2[XW-1:1];
        assign bank_we = wr_en && ({wx[0], wz[0]} == 2'(b));

        hbs_ram #(
            .WIDTH (8),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we),
            .waddr ({wx[XW-1:1], wz[XW-1:1]}),
            .wdata (req.sample_value),
            .re    (accept_sample),
            .raddr ({rx, rz}),
            .rdata (bank_rdata[b])
        );
    end

    // ------------------------------------------------------------------
    // Stage 1: side data alongside the bank read
    // ------------------------------------------------------------------
    logic [7:0] fx1_reg, fz1_reg;
    logic [3:0] par1_reg;
    logic       oor1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            fx1_reg  <= req.pos_x[7:0];
            fz1_reg  <= req.pos_z[7:0];
            par1_reg <= {x1[0], x2[0], z1[0], z2[0]};
            oor1_reg <= clamp_any;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: interpolate along z
    // ------------------------------------------------------------------
    logic [7:0]  s11, s12, s21, s22;
    logic [8:0]  wz_lo;
    logic [16:0] a_sum, b_sum;
    logic [15:0] a_next, b_next;
    logic [15:0] a_reg, b_reg;
    logic [7:0]  fx2_reg;
    logic        oor2_reg;

    always_comb
    begin
        s11    = bank_rdata[{par1_reg[3], par1_reg[1]}];
        s12    = bank_rdata[{par1_reg[3], par1_reg[0]}];
        s21    = bank_rdata[{par1_reg[2], par1_reg[1]}];
        s22    = bank_rdata[{par1_reg[2], par1_reg[0]}];
        wz_lo  = 9'd256 - {1'b0, fz1_reg};
        a_sum  = 17'(s11 * wz_lo) + 17'(s12 * fz1_reg);
        b_sum  = 17'(s21 * wz_lo) + 17'(s22 * fz1_reg);
        a_next = a_sum[15:0];
        b_next = b_sum[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            fx2_reg  <= fx1_reg;
            oor2_reg <= oor1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: interpolate along x
    // ------------------------------------------------------------------
    logic [8:0]  wx_lo;
    logic [24:0] r_sum;
    logic [23:0] r_next;
    logic [23:0] r_reg;
    logic        oor3_reg;

    always_comb
    begin
        wx_lo  = 9'd256 - {1'b0, fx2_reg};
        r_sum  = 25'(a_reg * wx_lo) + 25'(b_reg * fx2_reg);
        r_next = r_sum[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            r_reg    <= r_next;
            oor3_reg <= oor2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale by max_height, add the rounding half, drop 8 bits
    // ------------------------------------------------------------------
    logic [31:0] n_scaled;
    logic [23:0] m_next;
    logic [23:0] m4_reg;
    logic        oor4_reg;

    always_comb
    begin
        n_scaled = 32'(r_reg * max_height_reg) + hbs_pkg::ROUND_HALF;
        m_next   = n_scaled[31:8];
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            m4_reg   <= m_next;
            oor4_reg <= oor3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: quotient estimate by 255, low by at most one
    // ------------------------------------------------------------------
    logic [32:0] q_prod;
    logic [15:0] q_next;
    logic [15:0] q5_reg;
    logic [23:0] m5_reg;
    logic        oor5_reg;

    always_comb
    begin
        q_prod = 33'(m4_reg * hbs_pkg::RECIP_255);
        q_next = q_prod[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            q5_reg   <= q_next;
            m5_reg   <= m4_reg;
            oor5_reg <= oor4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: correct the estimate from the remainder
    // ------------------------------------------------------------------
    logic [23:0] q_times;
    logic [23:0] rem;
    hbs_pkg::rsp_item_t rsp_next;
    hbs_pkg::rsp_item_t rsp_reg;

    always_comb
    begin
        q_times = {q5_reg, 8'd0} - {8'd0, q5_reg};
        rem     = m5_reg - q_times;
        rsp_next.height       = (rem >= hbs_pkg::FULL_SCALE) ? q5_reg + 16'd1 : q5_reg;
        rsp_next.out_of_range = oor5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- src/hbs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sim/height_sampler_checker.sv -----
`timescale 1ns / 1ps

module height_sampler_checker #(
    parameter int MAP_SIZE = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  hbs_pkg::req_item_t req,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  hbs_pkg::rsp_item_t rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 failures,
    output int                 pending
);

    // full scale of a sample times the Q0.8 weight sum
    localparam longint unsigned SCALE_DIV = 255 * 256;

    logic [7:0]         map_copy [0:MAP_SIZE*MAP_SIZE-1];
    logic [7:0]         scale;
    hbs_pkg::rsp_item_t height_queue [$];
    int                 error_count = 0;

    assign failures = error_count;

    function automatic int clamp_index(int idx);
        if (idx < 0)
            return 0;
        if (idx > MAP_SIZE - 1)
            return MAP_SIZE - 1;
        return idx;
    endfunction

    // Bilinear height at a Q8.8 position: along z first, then along x, then scale
    function automatic hbs_pkg::rsp_item_t predict_height(logic [15:0] px, logic [15:0] pz);
        int                 xa, za, xlo, xhi, zlo, zhi;
        longint unsigned    fx, fz, a, b, r;
        hbs_pkg::rsp_item_t res;
        xa  = int'($signed(px[15:8])) + MAP_SIZE / 2;
        za  = int'($signed(pz[15:8])) + MAP_SIZE / 2;
        fx  = px[7:0];
        fz  = pz[7:0];
        xlo = clamp_index(xa);
        xhi = clamp_index(xa + 1);
        zlo = clamp_index(za);
        zhi = clamp_index(za + 1);
        a = map_copy[xlo * MAP_SIZE + zlo] * (256 - fz) + map_copy[xlo * MAP_SIZE + zhi] * fz;
        b = map_copy[xhi * MAP_SIZE + zlo] * (256 - fz) + map_copy[xhi * MAP_SIZE + zhi] * fz;
        r = a * (256 - fx) + b * fx;
        res.height       = 16'((r * scale + hbs_pkg::ROUND_HALF) / SCALE_DIV);
        res.out_of_range = (xlo != xa) || (xhi != xa + 1) || (zlo != za) || (zhi != za + 1);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hbs_pkg::rsp_item_t want;
        if (!rst_n)
        begin
            scale = hbs_pkg::MAX_HEIGHT_RESET;
            height_queue.delete();
            pending <= 0;
        end
        else
        begin
            // follow register writes
            if (psel && penable && pwrite && pready && paddr[2] == hbs_pkg::REG_MAX_HEIGHT)
                scale = pwdata[7:0];

            // compare a delivered result with the oldest prediction
            if (rsp_valid && rsp_ready)
            begin
                if (height_queue.size() == 0)
                begin
                    $error("unexpected result: height %0d, out_of_range %0d",
                           rsp.height, rsp.out_of_range);
                    error_count++;
                end
                else
                begin
                    want = height_queue.pop_front();
                    if (rsp.height !== want.height)
                    begin
                        $error("height: expected %0d, got %0d", want.height, rsp.height);
                        error_count++;
                    end
                    if (rsp.out_of_range !== want.out_of_range)
                    begin
                        $error("out_of_range: expected %0d, got %0d",
                               want.out_of_range, rsp.out_of_range);
                        error_count++;
                    end
                end
            end

            // update the map on writes, predict on samples
            if (req_valid && req_ready)
            begin
                if (req.kind == hbs_pkg::KIND_WRITE)
                begin
                    if (req.x_index < MAP_SIZE && req.z_index < MAP_SIZE)
                        map_copy[req.x_index * MAP_SIZE + req.z_index] = req.sample_value;
                end
                else
                    height_queue.push_back(predict_height(req.pos_x, req.pos_z));
            end

            pending <= height_queue.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int MAP_SIZE     = 256;
    localparam int ITEM_COUNT   = 1700;
    localparam int PHASES       = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1000000;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    hbs_pkg::req_item_t req;
    logic               rsp_valid;
    logic               rsp_ready;
    hbs_pkg::rsp_item_t rsp;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 failures;
    int                 pending;
    int                 cycles = 0;
    int                 sent = 0;
    bit                 calm = 1'b0;
    bit                 written [0:MAP_SIZE*MAP_SIZE-1];
    logic [7:0]         settings [0:PHASES-1];

    heightmap_bilinear_sampler_unit #(.MAP_SIZE(MAP_SIZE)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    height_sampler_checker #(.MAP_SIZE(MAP_SIZE)) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic int draw_wait();
        if (calm)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic int clamp_index(int idx);
        if (idx < 0)
            return 0;
        if (idx > MAP_SIZE - 1)
            return MAP_SIZE - 1;
        return idx;
    endfunction

    // Integer part of a position, mostly near the centre or either edge
    function automatic int region_int();
        case ($urandom_range(0, 3))
            0:       return int'($urandom_range(124, 127));
            1:       return int'($urandom_range(0, 3)) - 128;
            default: return int'($urandom_range(0, 6)) - 3;
        endcase
    endfunction

    // Present one item after a random gap and hold it until taken
    task automatic send_item(hbs_pkg::req_item_t item);
        int gap;
        gap = draw_wait();
        if ($urandom_range(0, 63) == 0)
            calm = !calm;
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        req       = item;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic store_sample(int x, int z, logic [7:0] value);
        hbs_pkg::req_item_t item;
        item.kind         = hbs_pkg::KIND_WRITE;
        item.pos_x        = 16'($urandom);
        item.pos_z        = 16'($urandom);
        item.x_index      = x[7:0];
        item.z_index      = z[7:0];
        item.sample_value = value;
        send_item(item);
        written[x * MAP_SIZE + z] = 1'b1;
    endtask

    // Fill any unwritten neighbour first, then ask for the height
    task automatic probe_height(logic [15:0] px, logic [15:0] pz);
        hbs_pkg::req_item_t item;
        int                 xs [2];
        int                 zs [2];
        xs[0] = clamp_index(int'($signed(px[15:8])) + MAP_SIZE / 2);
        xs[1] = clamp_index(int'($signed(px[15:8])) + MAP_SIZE / 2 + 1);
        zs[0] = clamp_index(int'($signed(pz[15:8])) + MAP_SIZE / 2);
        zs[1] = clamp_index(int'($signed(pz[15:8])) + MAP_SIZE / 2 + 1);
        for (int i = 0; i < 2; i++)
            for (int k = 0; k < 2; k++)
                if (!written[xs[i] * MAP_SIZE + zs[k]])
                    store_sample(xs[i], zs[k], 8'($urandom));
        item.kind         = hbs_pkg::KIND_SAMPLE;
        item.pos_x        = px;
        item.pos_z        = pz;
        item.x_index      = 8'($urandom);
        item.z_index      = 8'($urandom);
        item.sample_value = 8'($urandom);
        send_item(item);
    endtask

    // Drop valid and wait until every result is back and the pipe is empty
    task automatic settle();
        req_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [7:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {hbs_pkg::REG_MAX_HEIGHT, 2'b00};
        pwdata  = {24'd0, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Result side: stall at random before each item
    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                rsp_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready = 1'b1;
            do @(posedge clk); while (!rsp_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        int pick;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        settings  = '{8'd255, 8'd0, 8'd1, 8'd0, 8'd254, 8'd128, 8'd0, 8'd30};
        settings[3] = 8'($urandom);
        settings[6] = 8'($urandom);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Full-scale cell at the map centre, exact and with extreme fractions
        store_sample(128, 128, 8'd255);
        store_sample(128, 129, 8'd255);
        store_sample(129, 128, 8'd255);
        store_sample(129, 129, 8'd255);
        probe_height(16'h0000, 16'h0000);
        probe_height(16'h00FF, 16'h0080);
        // most negative position
        store_sample(0, 0, 8'd0);
        probe_height(16'h8000, 16'h8000);
        // most positive position clamps both axes
        store_sample(255, 255, 8'd255);
        probe_height(16'h7FFF, 16'h7FFF);
        // clamp on one axis only
        probe_height(16'h7F00, 16'h8000);
        probe_height(16'h80FF, 16'h7F01);
        // overwrite and negative fractional positions
        store_sample(128, 128, 8'd0);
        probe_height(16'h0000, 16'h0000);
        probe_height(16'hFF80, 16'h0140);

        // Random phases, one height scale each
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_register(settings[p]);
            while (sent < (p + 1) * ITEM_COUNT / PHASES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    store_sample($urandom_range(0, 255), $urandom_range(0, 255), 8'($urandom));
                else if (pick < 12)
                    store_sample(region_int() + 128, region_int() + 128, 8'($urandom));
                else if (pick < 22)
                    probe_height(16'($urandom), 16'($urandom));
                else
                    probe_height({8'(region_int()), 8'($urandom)},
                                 {8'(region_int()), 8'($urandom)});
            end
        end

        settle();
        if (failures == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
